// ===== sv/shfa_pkg.sv =====
// Package for the simhash fingerprint accumulator.
// Holds channel widths and the queue-head status struct; no dependencies.
package shfa_pkg;

   localparam int unsigned HASH_W = 64;   // token_hash field width
   localparam int unsigned FP_W   = 64;   // fingerprint field width

   // Status of the entry at the head of the front queue, seen by the back end.
   typedef struct packed {
      logic valid;
      logic last;
   } shfa_head_type;

endpackage

// ===== sv/shfa_channels.sv =====
// Valid/ready channel interfaces for token transfers in and fingerprints out.
// Depends on shfa_pkg for the field widths.
interface shfa_req_if
   import shfa_pkg::*;
   ;
   logic              valid;
   logic              ready;
   logic [HASH_W-1:0] token_hash;
   logic              last_token;

   modport source (output valid, output token_hash, output last_token, input ready);
   modport sink   (input valid, input token_hash, input last_token, output ready);
endinterface

interface shfa_rsp_if
   import shfa_pkg::*;
   ;
   logic            valid;
   logic            ready;
   logic [FP_W-1:0] fingerprint;

   modport source (output valid, output fingerprint, input ready);
   modport sink   (input valid, input fingerprint, output ready);
endinterface

// ===== sv/shfa_front.sv =====
// Front end: accepts token transfers into a two-entry queue.
// Depends on shfa_pkg and shfa_req_if; feeds shfa_back.
module shfa_front
   import shfa_pkg::*;
#(
   parameter int unsigned HASH_BITS = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   shfa_req_if.sink             req_chan,
   output shfa_head_type        head,
   output logic [HASH_BITS-1:0] head_hash,
   input  logic                 pop
);

   localparam int unsigned DEPTH = 2;

   logic [HASH_BITS-1:0] hash_ff [DEPTH];
   logic                 last_ff [DEPTH];
   logic                 wr_ptr_ff, wr_ptr_in;
   logic                 rd_ptr_ff, rd_ptr_in;
   logic [1:0]           count_ff, count_in;
   logic                 push;

   assign req_chan.ready = (count_ff != 2'(DEPTH));
   assign push           = req_chan.valid && req_chan.ready;

   assign head.valid = (count_ff != 2'd0);
   assign head.last  = last_ff[rd_ptr_ff];
   assign head_hash  = hash_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         hash_ff[wr_ptr_ff] <= req_chan.token_hash[HASH_BITS-1:0];
         last_ff[wr_ptr_ff] <= req_chan.last_token;
      end
   end

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'(DEPTH))
      else $error("queue occupancy out of range");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != 2'd0)
      else $error("pop from empty queue");

   a_count_track: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> count_ff == $past(count_ff) + 2'($past(push)) - 2'($past(pop)))
      else $error("queue occupancy lost track of transfers");
`endif

endmodule

// ===== sv/shfa_back.sv =====
// Back end: per-bit saturating vote counters and the fingerprint output register.
// Depends on shfa_pkg and shfa_rsp_if; takes entries from shfa_front.
module shfa_back
   import shfa_pkg::*;
#(
   parameter int unsigned HASH_BITS  = 64,
   parameter int unsigned VOTE_WIDTH = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  shfa_head_type        head,
   input  logic [HASH_BITS-1:0] head_hash,
   output logic                 pop,
   shfa_rsp_if.source           rsp_chan
);

   localparam logic [VOTE_WIDTH-1:0] VOTE_MAX = {1'b0, {(VOTE_WIDTH-1){1'b1}}};
   localparam logic [VOTE_WIDTH-1:0] VOTE_MIN = {1'b1, {(VOTE_WIDTH-1){1'b0}}};

   logic [VOTE_WIDTH-1:0] vote_ff [HASH_BITS];
   logic [VOTE_WIDTH-1:0] vote_in [HASH_BITS];
   logic [HASH_BITS-1:0]  positive;
   logic                  out_free;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [FP_W-1:0]       fp_ff, fp_in;

   // Non-last entries never wait on the output side.
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign pop      = head.valid && (!head.last || out_free);

   always_comb begin
      for (int j = 0; j < HASH_BITS; j++) begin
         if (head_hash[j])
            vote_in[j] = (vote_ff[j] != VOTE_MAX) ? vote_ff[j] + 1'b1 : vote_ff[j];
         else
            vote_in[j] = (vote_ff[j] != VOTE_MIN) ? vote_ff[j] - 1'b1 : vote_ff[j];
         positive[j] = !vote_in[j][VOTE_WIDTH-1] && (vote_in[j] != '0);
      end
   end

   // Counter j lands on fingerprint bit HASH_BITS-1-j; upper bits stay zero.
   always_comb begin
      fp_in = '0;
      for (int j = 0; j < HASH_BITS; j++)
         fp_in[HASH_BITS-1-j] = positive[j];
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (pop && head.last)
         rsp_valid_in = 1'b1;
      else if (rsp_chan.ready)
         rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         for (int j = 0; j < HASH_BITS; j++)
            vote_ff[j] <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            for (int j = 0; j < HASH_BITS; j++)
               vote_ff[j] <= head.last ? '0 : vote_in[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop && head.last)
         fp_ff <= fp_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.fingerprint = fp_ff;

`ifndef ASSERT_OFF
   a_last_emits: assert property (@(posedge clock) disable iff (reset)
      pop && head.last |=> rsp_valid_ff)
      else $error("last token did not produce a fingerprint");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      pop && head.last |=> vote_ff[0] == '0 && vote_ff[HASH_BITS-1] == '0)
      else $error("vote counters not cleared after document end");

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $rose(rsp_valid_ff) |-> $past(pop && head.last))
      else $error("fingerprint raised without a last token");
`endif

endmodule

// ===== sv/simhash_fingerprint_accumulator.sv =====
// A transferred token is first registered in the front queue and is counted into the vote
// registers as it is popped; a popped last token loads the fingerprint register and clears the votes.
// Throughput: one token per cycle while nothing stalls, set by the parallel add/subtract of all vote lanes.
// A held fingerprint stalls the next last token; later tokens stall once the queue fills.
// Reset (synchronous, active high) clears all vote counters, the queue and the output valid.
// Depends on shfa_pkg, shfa_channels, shfa_front, shfa_back.
module simhash_fingerprint_accumulator
   import shfa_pkg::*;
#(
   parameter int unsigned HASH_BITS  = 64,  // counted hash bits, 8..64
   parameter int unsigned VOTE_WIDTH = 16   // signed counter width, 4..32
) (
   input  logic        clock,
   input  logic        reset,
   shfa_req_if.sink    req_chan,
   shfa_rsp_if.source  rsp_chan
);

   // Queue head status and pop between the two halves.
   shfa_head_type        head;
   logic [HASH_BITS-1:0] head_hash;
   logic                 pop;

   // Front: two-entry queue; tokens behind a stalled last token still transfer until it fills.
   shfa_front #(
      .HASH_BITS (HASH_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .head      (head),
      .head_hash (head_hash),
      .pop       (pop)
   );

   // Back: saturating vote lanes, threshold and bit reversal, output register.
   shfa_back #(
      .HASH_BITS  (HASH_BITS),
      .VOTE_WIDTH (VOTE_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .head_hash (head_hash),
      .pop       (pop),
      .rsp_chan  (rsp_chan)
   );

endmodule

// ===== test/simhash_fingerprint_accumulator_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for simhash_fingerprint_accumulator.
// Depends on shfa_pkg, the shfa_channels interfaces and the block itself.
module simhash_fingerprint_accumulator_test;
   import shfa_pkg::*;

   // Block configuration under test; the predictor uses the same values.
   localparam int unsigned HASH_N = 64;
   localparam int unsigned VOTE_W = 16;

   // Saturation limits of one signed vote counter.
   localparam logic signed [VOTE_W-1:0] VOTE_TOP    = {1'b0, {(VOTE_W-1){1'b1}}};
   localparam logic signed [VOTE_W-1:0] VOTE_BOTTOM = {1'b1, {(VOTE_W-1){1'b0}}};

   // Long receiver hold-off that backs up the block and stalls its input.
   localparam int LONG_HOLD   = 300;
   localparam int HOLD_AFTER  = 12;   // fingerprints seen before the hold starts
   localparam int TAIL_TOKENS = 80;   // last tokens sent without idling
   localparam int RANDOM_ITEMS = 500;

   typedef struct {
      logic [HASH_W-1:0] hash;
      logic              last;
   } token_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   shfa_req_if req_bus();
   shfa_rsp_if rsp_bus();

   simhash_fingerprint_accumulator #(
      .HASH_BITS  (HASH_N),
      .VOTE_WIDTH (VOTE_W)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predictor state: one saturating vote counter per hash bit.
   logic signed [VOTE_W-1:0] vote_tally [HASH_N];
   logic [FP_W-1:0]          expected_prints [$];

   token_item_type pending_tokens [$];
   token_item_type shown;         // item currently offered on the request channel
   logic        quiet_tail = 1'b0;

   int error_count = 0;
   int tokens_sent = 0;
   int docs_predicted = 0;
   int fp_seen = 0;
   int send_gap = 0;
   int stall_left = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;
   logic [FP_W-1:0] want_print;

   task automatic report_mismatch(input string what, input logic [FP_W-1:0] want,
                                  input logic [FP_W-1:0] got);
      $display("MISMATCH at %0t: %s expected %h got %h", $realtime, what, want, got);
      error_count++;
   endtask

   // Count one transferred token; on the last token of a document, form the
   // fingerprint (bit order reversed against the counters) and clear the votes.
   task automatic count_token(input logic [HASH_W-1:0] hash, input logic last);
      logic [FP_W-1:0] print;
      print = '0;
      for (int j = 0; j < HASH_N; j++) begin
         if (hash[j]) begin
            if (vote_tally[j] != VOTE_TOP) vote_tally[j] += 1;
         end else if (vote_tally[j] != VOTE_BOTTOM) begin
            vote_tally[j] -= 1;
         end
      end
      if (last) begin
         for (int j = 0; j < HASH_N; j++) begin
            if (vote_tally[j] > 0) print[HASH_N-1-j] = 1'b1;  // ties stay 0
            vote_tally[j] = '0;
         end
         expected_prints.push_back(print);
         docs_predicted++;
      end
   endtask

   task automatic add_token(input logic [HASH_W-1:0] hash, input logic last);
      token_item_type item;
      item.hash = hash;
      item.last = last;
      pending_tokens.push_back(item);
   endtask

   function automatic logic [HASH_W-1:0] rand_hash();
      return {$urandom, $urandom};
   endfunction

   // Driver: offers queued tokens, predicts on each transfer, idles in short bursts.
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid      <= 1'b0;
         req_bus.token_hash <= '0;
         req_bus.last_token <= 1'b0;
         send_gap = 0;
         for (int j = 0; j < HASH_N; j++) vote_tally[j] = '0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            count_token(shown.hash, shown.last);
            tokens_sent++;
         end
         if (pending_tokens.size() < TAIL_TOKENS) quiet_tail <= 1'b1;
         if (!req_bus.valid || req_bus.ready) begin
            if (send_gap > 0 && !quiet_tail) begin
               send_gap--;
               req_bus.valid <= 1'b0;
            end else if (pending_tokens.size() > 0) begin
               shown = pending_tokens.pop_front();
               req_bus.valid      <= 1'b1;
               req_bus.token_hash <= shown.hash;
               req_bus.last_token <= shown.last;
               send_gap = 0;
               if (!quiet_tail && $urandom_range(0, 4) == 0) send_gap = $urandom_range(1, 3);
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: random short stalls, one long hold-off, none near the end.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (!hold_done && fp_seen >= HOLD_AFTER) begin
            hold_left = LONG_HOLD;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (quiet_tail) begin
            rsp_bus.ready <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            if ($urandom_range(0, 4) == 0) stall_left = $urandom_range(1, 3);
         end
      end
   end

   // Monitor: every fingerprint transfer is checked against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         fp_seen++;
         if (expected_prints.size() == 0) begin
            report_mismatch("unexpected fingerprint", '0, rsp_bus.fingerprint);
         end else begin
            want_print = expected_prints.pop_front();
            if (rsp_bus.fingerprint !== want_print)
               report_mismatch("fingerprint", want_print, rsp_bus.fingerprint);
         end
      end
   end

   // Stimulus and end of run.
   initial begin
      logic [HASH_W-1:0] base;
      logic [HASH_W-1:0] h;
      int doc_len;
      int style;
      int queued;

      // Directed: field extremes and the named corner cases.
      add_token({HASH_W{1'b1}}, 1'b1);            // single token, all votes up
      add_token({HASH_W{1'b0}}, 1'b1);            // single token, all votes down
      add_token(64'h0000_0000_0000_0001, 1'b1);   // lowest bit maps to top of print
      add_token(64'h8000_0000_0000_0000, 1'b1);   // top bit maps to bottom
      add_token(64'h0123_4567_89AB_CDEF, 1'b0);   // exact tie on every bit
      add_token(~64'h0123_4567_89AB_CDEF, 1'b1);
      add_token(64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
      add_token(64'h5555_5555_5555_5555, 1'b1);
      add_token(64'hFFFF_0000_FFFF_0000, 1'b0);   // 2-of-3 majority per bit
      add_token(64'hFF00_FF00_FF00_FF00, 1'b0);
      add_token(64'hF0F0_F0F0_F0F0_F0F0, 1'b1);
      add_token(64'hDEAD_BEEF_0BAD_F00D, 1'b0);   // tie then one odd vote
      add_token(~64'hDEAD_BEEF_0BAD_F00D, 1'b0);
      add_token(64'h0F0F_1234_8000_0001, 1'b1);

      // Random documents of mixed shape and length.
      queued = 0;
      while (queued < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0, 1:    doc_len = 1;
            8:       doc_len = $urandom_range(9, 30);
            default: doc_len = $urandom_range(2, 8);
         endcase
         style = $urandom_range(0, 3);
         base = rand_hash();
         for (int k = 0; k < doc_len; k++) begin
            case (style)
               0: h = rand_hash();
               1: h = base ^ (rand_hash() & rand_hash() & rand_hash());  // skewed votes
               2: h = (k % 2 == 0) ? base : ~base;                         // near ties
               default: h = ($urandom_range(0, 1) == 1) ? (rand_hash() & rand_hash())
                                                       : (rand_hash() | rand_hash());
            endcase
            add_token(h, k == doc_len - 1);
            queued++;
         end
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (pending_tokens.size() > 0 || req_bus.valid) @(posedge clock);
      while (expected_prints.size() > 0) @(posedge clock);
      repeat (10) @(posedge clock);

      if (expected_prints.size() > 0)
         report_mismatch("fingerprints never delivered", FP_W'(expected_prints.size()), '0);

      $display("Covered %0d token transfers and %0d documents, including single-token",
               tokens_sent, docs_predicted);
      $display("documents, exact ties, random stalls on both sides and a %0d-cycle hold-off.",
               LONG_HOLD);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Run limit, far beyond the slowest correct run.
   initial begin
      #30_000_000;
      $display("Timeout: %0d fingerprints still outstanding", expected_prints.size());
      $display("DONE: errors detected");
      $finish;
   end

endmodule
